// ----- rtl/osd_screen_selector_defines.svh -----
// Assertion macros for the display screen selector.
`ifndef OSD_SCREEN_SELECTOR_DEFINES_SVH
`define OSD_SCREEN_SELECTOR_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, checked outside reset.
`define OSS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("osd_screen_selector: same-cycle check failed");
// Next-cycle implication, checked outside reset.
`define OSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("osd_screen_selector: next-cycle check failed");
`else
`define OSS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define OSS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- rtl/oss_pkg.sv -----
// Shared types, constants and helper functions for the screen selector.
package oss_pkg;

    // Default screen count and fixed field widths
    localparam int SCREEN_COUNT_DEF = 4;
    localparam int SCR_W            = 2;
    localparam int MASK_W           = 4;
    localparam int EVT_W            = 3;
    localparam int MODE_W           = 2;
    localparam int PULSE_W          = 12;
    localparam int TIME_W           = 32;
    localparam int TABLE_W          = 64;
    localparam int BOUND_W          = 16;
    localparam int CFG_IDX_W        = 3;
    localparam int CFG_DATA_W       = 64;
    localparam int IN_DATA_W        = 48;
    localparam int OUT_DATA_W       = 8;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE_MASK   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ARM_SCREEN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DISARM_SCREEN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FS_SCREEN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SWITCH_MODE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_TRIM  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH    = 3'd7;

    // Switch channel modes
    localparam logic [MODE_W-1:0] MODE_OFF    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TOGGLE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RANGE  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_AUTO   = 2'd3;

    // Reset values of the registers
    localparam logic [MASK_W-1:0]  MASK_RST = 4'd1;
    localparam logic [MODE_W-1:0]  MODE_RST = MODE_TOGGLE;
    localparam logic [PULSE_W-1:0] TRIM_RST = 12'd1500;

    // Toggle swing and auto advance period
    localparam logic [PULSE_W-1:0] SWING_LIMIT    = 12'd200;
    localparam logic [TIME_W-1:0]  ADVANCE_PERIOD = 32'd1000;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic event_step;
        logic chan_step;
        logic scan_step;
        logic out_load;
    } oss_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic need_scan;
        logic scan_done;
    } oss_status_t;

    // Screen idx is enabled and below the screen count
    function automatic logic scr_on(input logic [MASK_W-1:0] mask,
                                    input logic [EVT_W-1:0] idx,
                                    input int count);
        return (int'(idx) < count) && mask[idx[SCR_W-1:0]];
    endfunction

    // One-based event screen number usable as a jump target
    function automatic logic event_ok(input logic [MASK_W-1:0] mask,
                                      input logic [EVT_W-1:0] num,
                                      input int count);
        return (num != '0) && scr_on(mask, num - 3'd1, count);
    endfunction

endpackage

// ----- rtl/oss_ctrl.sv -----
// Sequencing state machine and output beat handshake of the screen selector.
module oss_ctrl
    import oss_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  oss_status_t status,
    output oss_cmd_t    cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EVENT = 3'd1;
    localparam logic [2:0] S_CHAN  = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       slot_free;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign slot_free     = !out_valid_reg || m_axis_tready;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EVENT;
                end
            end
            S_EVENT:
            begin
                cmd.event_step = 1'b1;
                state_next     = S_CHAN;
            end
            S_CHAN:
            begin
                cmd.chan_step = 1'b1;
                state_next    = status.need_scan ? S_SCAN : S_DONE;
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output beat valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- rtl/oss_datapath.sv -----
// Registers, event logic, channel handling and screen scan unit of the selector.
module oss_datapath
    import oss_pkg::*;
#(
    parameter int SCREEN_COUNT = SCREEN_COUNT_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [IN_DATA_W-1:0]  in_data,
    input  oss_cmd_t              cmd,
    output oss_status_t           status,
    output logic [OUT_DATA_W-1:0] out_data
);

    localparam logic [SCR_W-1:0] LAST_SCR = SCR_W'(SCREEN_COUNT - 1);

    // Configuration registers
    logic [MASK_W-1:0]  mask_reg;
    logic [EVT_W-1:0]   arm_scr_reg, disarm_scr_reg, fs_scr_reg;
    logic [MODE_W-1:0]  mode_reg;
    logic [PULSE_W-1:0] trim_reg;
    logic [TABLE_W-1:0] range_lo_reg, range_hi_reg;

    // Latched input beat
    logic               in_armed_reg, in_fs_reg, in_valid_reg;
    logic [PULSE_W-1:0] in_pw_reg;
    logic [TIME_W-1:0]  in_time_reg;

    // Selector state
    logic [SCR_W-1:0]   screen_reg, screen_next;
    logic               was_armed_reg, was_armed_next;
    logic               was_fs_reg, was_fs_next;
    logic [SCR_W-1:0]   saved_scr_reg, saved_scr_next;
    logic [PULSE_W-1:0] last_pulse_reg, last_pulse_next;
    logic               deb_reg, deb_next;
    logic [TIME_W-1:0]  last_adv_reg, last_adv_next;

    // Scan unit
    logic [SCR_W-1:0]   cand_reg, cand_next;
    logic               scan_range_reg, scan_range_next;
    logic [SCR_W-1:0]   out_scr_reg;

    logic [SCR_W-1:0]   evt_scr;
    logic [PULSE_W-1:0] lp;
    logic [PULSE_W-1:0] diff;
    logic [TIME_W-1:0]  elapsed;
    logic [BOUND_W-1:0] lo_bound, hi_bound;
    logic [BOUND_W-1:0] pw_ext;
    logic               need_adv, need_range;
    logic               cand_on, hit, last_cand;

    function automatic logic [SCR_W-1:0] scr_next(input logic [SCR_W-1:0] t);
        return (t == LAST_SCR) ? '0 : t + 2'd1;
    endfunction

    assign out_data = {{(OUT_DATA_W-SCR_W){1'b0}}, out_scr_reg};

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg       <= MASK_RST;
            arm_scr_reg    <= '0;
            disarm_scr_reg <= '0;
            fs_scr_reg     <= '0;
            mode_reg       <= MODE_RST;
            trim_reg       <= TRIM_RST;
            range_lo_reg   <= '0;
            range_hi_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ENABLE_MASK:   mask_reg       <= cfg_data[MASK_W-1:0];
                REG_ARM_SCREEN:    arm_scr_reg    <= cfg_data[EVT_W-1:0];
                REG_DISARM_SCREEN: disarm_scr_reg <= cfg_data[EVT_W-1:0];
                REG_FS_SCREEN:     fs_scr_reg     <= cfg_data[EVT_W-1:0];
                REG_SWITCH_MODE:   mode_reg       <= cfg_data[MODE_W-1:0];
                REG_CHANNEL_TRIM:  trim_reg       <= cfg_data[PULSE_W-1:0];
                REG_RANGE_LOW:     range_lo_reg   <= cfg_data[TABLE_W-1:0];
                REG_RANGE_HIGH:    range_hi_reg   <= cfg_data[TABLE_W-1:0];
                default:           mask_reg       <= mask_reg;
            endcase
        end
    end

    // Input beat capture, output register and scan candidate registers (payload, no reset)
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            in_armed_reg <= in_data[0];
            in_fs_reg    <= in_data[1] | in_data[2];
            in_valid_reg <= in_data[3];
            in_pw_reg    <= in_data[15:4];
            in_time_reg  <= in_data[47:16];
        end
        if (cmd.out_load)
        begin
            out_scr_reg <= screen_reg;
        end
        cand_reg       <= cand_next;
        scan_range_reg <= scan_range_next;
    end

    // Arm, disarm and failsafe edges
    always_comb
    begin
        evt_scr        = screen_reg;
        was_armed_next = was_armed_reg;
        was_fs_next    = was_fs_reg;
        saved_scr_next = saved_scr_reg;
        if (in_armed_reg)
        begin
            if (!was_armed_reg && event_ok(mask_reg, arm_scr_reg, SCREEN_COUNT))
            begin
                evt_scr = SCR_W'(arm_scr_reg - 3'd1);
            end
            was_armed_next = 1'b1;
        end
        else if (was_armed_reg)
        begin
            if (event_ok(mask_reg, disarm_scr_reg, SCREEN_COUNT))
            begin
                evt_scr = SCR_W'(disarm_scr_reg - 3'd1);
            end
            was_armed_next = 1'b0;
        end
        if (in_fs_reg)
        begin
            if (!was_fs_reg && event_ok(mask_reg, fs_scr_reg, SCREEN_COUNT))
            begin
                saved_scr_next = evt_scr;
                evt_scr        = SCR_W'(fs_scr_reg - 3'd1);
            end
            was_fs_next = 1'b1;
        end
        else if (was_fs_reg)
        begin
            if (scr_on(mask_reg, {1'b0, saved_scr_reg}, SCREEN_COUNT))
            begin
                evt_scr = saved_scr_reg;
            end
            was_fs_next = 1'b0;
        end
    end

    // Channel arithmetic: swing against last pulse, time since last advance
    assign lp      = (last_pulse_reg == '0) ? in_pw_reg : last_pulse_reg;
    assign diff    = (in_pw_reg > lp) ? (in_pw_reg - lp) : (lp - in_pw_reg);
    assign elapsed = in_time_reg - last_adv_reg;

    // Scan candidate checks
    assign lo_bound  = range_lo_reg[{cand_reg, 4'b0000} +: BOUND_W];
    assign hi_bound  = range_hi_reg[{cand_reg, 4'b0000} +: BOUND_W];
    assign pw_ext    = {{(BOUND_W-PULSE_W){1'b0}}, in_pw_reg};
    assign cand_on   = scr_on(mask_reg, {1'b0, cand_reg}, SCREEN_COUNT);
    assign hit       = scan_range_reg
                     ? (cand_on && (lo_bound <= pw_ext) && (hi_bound > pw_ext))
                     : ((cand_reg == screen_reg) || cand_on);
    assign last_cand = scan_range_reg && (cand_reg == LAST_SCR);

    // Channel mode decisions
    always_comb
    begin
        need_adv        = 1'b0;
        need_range      = 1'b0;
        last_pulse_next = last_pulse_reg;
        deb_next        = deb_reg;
        last_adv_next   = last_adv_reg;
        if (in_valid_reg)
        begin
            case (mode_reg)
                MODE_TOGGLE:
                begin
                    last_pulse_next = lp;
                    deb_next        = 1'b0;
                    if (diff > SWING_LIMIT)
                    begin
                        if (deb_reg)
                        begin
                            need_adv        = 1'b1;
                            last_pulse_next = in_pw_reg;
                        end
                        else
                        begin
                            deb_next = 1'b1;
                        end
                    end
                end
                MODE_RANGE:
                begin
                    need_range = 1'b1;
                    deb_next   = 1'b0;
                end
                MODE_AUTO:
                begin
                    deb_next = 1'b0;
                    if (in_pw_reg > trim_reg)
                    begin
                        if (deb_reg)
                        begin
                            if (elapsed > ADVANCE_PERIOD)
                            begin
                                need_adv      = 1'b1;
                                last_adv_next = in_time_reg;
                            end
                        end
                        else
                        begin
                            deb_next = 1'b1;
                        end
                    end
                    else
                    begin
                        last_adv_next = '0;
                    end
                end
                default:
                begin
                    need_adv = 1'b0;
                end
            endcase
        end
    end

    assign status.need_scan = need_adv || need_range;
    assign status.scan_done = hit || last_cand;

    // Screen and scan unit updates
    always_comb
    begin
        screen_next     = screen_reg;
        cand_next       = cand_reg;
        scan_range_next = scan_range_reg;
        if (cmd.event_step)
        begin
            screen_next = evt_scr;
        end
        if (cmd.chan_step)
        begin
            cand_next       = need_range ? '0 : scr_next(screen_reg);
            scan_range_next = need_range;
        end
        if (cmd.scan_step)
        begin
            if (hit)
            begin
                screen_next = cand_reg;
            end
            else
            begin
                cand_next = scr_next(cand_reg);
            end
        end
    end

    // Selector state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_reg     <= '0;
            was_armed_reg  <= 1'b0;
            was_fs_reg     <= 1'b0;
            saved_scr_reg  <= '0;
            last_pulse_reg <= '0;
            deb_reg        <= 1'b0;
            last_adv_reg   <= '0;
        end
        else
        begin
            screen_reg <= screen_next;
            if (cmd.event_step)
            begin
                was_armed_reg <= was_armed_next;
                was_fs_reg    <= was_fs_next;
                saved_scr_reg <= saved_scr_next;
            end
            if (cmd.chan_step)
            begin
                last_pulse_reg <= last_pulse_next;
                deb_reg        <= deb_next;
                last_adv_reg   <= last_adv_next;
            end
        end
    end

endmodule

// ----- rtl/osd_screen_selector.sv -----
// Top level of the display screen selector: controller, datapath and checks.
//
// One input beat per update tick on s_axis carries the armed and failsafe
// flags, the switch channel pulse width and the millisecond time; each beat
// yields exactly one output beat on m_axis with the selected screen index.
// Configuration registers are written through cfg_we / cfg_index / cfg_data,
// one register per cycle; the user must write them only while no tick is in
// flight, which the block itself does not enforce. The beat is captured, the
// event edges are resolved, then the channel mode, then the scan unit checks
// one screen per cycle (up to SCREEN_COUNT screens for a range select or an
// advance) before the result is loaded into the output register.
// s_axis_tready is high only while no tick is being worked on.
// If m_axis stalls, the finished result waits in the output register and the
// next tick is still accepted; its own result waits until the slot frees.
// Reset clears all selector state and loads the register reset values
// (screen 0 enabled, toggle mode, trim 1500); no output beat is pending.
`include "osd_screen_selector_defines.svh"

module osd_screen_selector
    import oss_pkg::*;
#(
    parameter int SCREEN_COUNT = SCREEN_COUNT_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // armed[0], radio_fs[1], battery_fs[2], channel_valid[3],
    // pulse_width[15:4], time_ms[47:16]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // shown_screen[1:0], zero fill above
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    oss_cmd_t    cmd;
    oss_status_t status;

    oss_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .status        (status),
        .cmd           (cmd)
    );

    oss_datapath #(
        .SCREEN_COUNT (SCREEN_COUNT)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (s_axis_tdata),
        .cmd       (cmd),
        .status    (status),
        .out_data  (m_axis_tdata)
    );

    // A captured beat blocks new input until its work is done
    `OSS_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    // The output register is loaded only when its slot is free
    `OSS_ASSERT_IMPL(a_load_free_slot, clk, rst_n, cmd.out_load, !m_axis_tvalid || m_axis_tready)
    // The shown screen always names an existing screen
    `OSS_ASSERT_IMPL(a_screen_range, clk, rst_n, m_axis_tvalid, int'(m_axis_tdata[1:0]) < SCREEN_COUNT)

endmodule

// ----- bench/tb_top.sv -----
// Self-checking bench for the display screen selector: tick driver, result monitor, predictor.
`timescale 1ns / 100ps

module tb_top;
    import oss_pkg::*;

    localparam int NSCR        = SCREEN_COUNT_DEF;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_AT     = 320;
    localparam int HOLD_LEN    = 120;
    localparam int SETTLE_CYC  = 12;
    localparam int RAND_PHASES = 10;
    localparam int PHASE_TICKS = 68;

    // One update tick, laid out exactly as on s_axis_tdata (lowest field last)
    typedef struct packed {
        logic [TIME_W-1:0]  ms;
        logic [PULSE_W-1:0] pulse;
        logic               chan_valid;
        logic               fs_batt;
        logic               fs_radio;
        logic               armed;
    } tick_t;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;

    osd_screen_selector u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Register mirror, reset values
    logic [MASK_W-1:0]  cfg_mask    = MASK_RST;
    logic [EVT_W-1:0]   cfg_arm     = '0;
    logic [EVT_W-1:0]   cfg_disarm  = '0;
    logic [EVT_W-1:0]   cfg_fs      = '0;
    logic [MODE_W-1:0]  cfg_mode    = MODE_RST;
    logic [PULSE_W-1:0] cfg_trim    = TRIM_RST;
    logic [TABLE_W-1:0] cfg_lo      = '0;
    logic [TABLE_W-1:0] cfg_hi      = '0;

    // Selector state as predicted
    logic [SCR_W-1:0]   sel_screen    = '0;
    logic               seen_armed    = 1'b0;
    logic               seen_failsafe = 1'b0;
    logic [SCR_W-1:0]   saved_screen  = '0;
    logic [PULSE_W-1:0] prev_pulse    = '0;
    logic               swing_armed   = 1'b0;
    logic [TIME_W-1:0]  advance_stamp = '0;

    // Ticks waiting to be sent, screens waiting to come out
    tick_t            tick_q[$];
    logic [SCR_W-1:0] screen_q[$];
    int               ticks_queued = 0;
    int               results_seen = 0;
    int               err_count    = 0;

    // Per-side idling switches, set per phase
    bit tx_idle_on = 1'b0;
    bit rx_idle_on = 1'b0;

    // Random tick generator state
    bit                gen_armed    = 1'b0;
    bit                gen_fs_radio = 1'b0;
    bit                gen_fs_batt  = 1'b0;
    logic [TIME_W-1:0] gen_ms       = '0;
    int                gen_pulse    = 1500;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        err_count++;
    endtask

    function automatic logic screen_enabled(input int i);
        return (i >= 0 && i < NSCR) ? cfg_mask[i] : 1'b0;
    endfunction

    // One-based event screen that names an enabled screen
    function automatic logic jump_target_ok(input logic [EVT_W-1:0] n);
        return (n != '0) && (int'(n) <= NSCR) && screen_enabled(int'(n) - 1);
    endfunction

    // Next enabled screen after 'from', or 'from' when there is none
    function automatic logic [SCR_W-1:0] next_enabled_screen(input logic [SCR_W-1:0] from);
        for (int s = 1; s <= NSCR; s++) begin
            if (screen_enabled((int'(from) + s) % NSCR))
                return SCR_W'((int'(from) + s) % NSCR);
        end
        return from;
    endfunction

    // Screen shown after one tick; updates the predicted state
    function automatic logic [SCR_W-1:0] select_screen(input tick_t t);
        logic               keep_flag;
        logic               hit;
        logic [PULSE_W-1:0] swing;
        logic [TIME_W-1:0]  elapsed;
        logic [BOUND_W-1:0] lo;
        logic [BOUND_W-1:0] hi;
        keep_flag = 1'b0;
        hit       = 1'b0;

        // arm / disarm edges
        if (t.armed) begin
            if (!seen_armed && jump_target_ok(cfg_arm))
                sel_screen = SCR_W'(cfg_arm - 3'd1);
            seen_armed = 1'b1;
        end else if (seen_armed) begin
            if (jump_target_ok(cfg_disarm))
                sel_screen = SCR_W'(cfg_disarm - 3'd1);
            seen_armed = 1'b0;
        end

        // failsafe entry saves the screen, exit restores it if still enabled
        if (t.fs_radio || t.fs_batt) begin
            if (!seen_failsafe && jump_target_ok(cfg_fs)) begin
                saved_screen = sel_screen;
                sel_screen   = SCR_W'(cfg_fs - 3'd1);
            end
            seen_failsafe = 1'b1;
        end else if (seen_failsafe) begin
            if (screen_enabled(int'(saved_screen)))
                sel_screen = saved_screen;
            seen_failsafe = 1'b0;
        end

        // switch channel
        if (cfg_mode != MODE_OFF && t.chan_valid) begin
            case (cfg_mode)
                MODE_TOGGLE: begin
                    if (prev_pulse == '0)
                        prev_pulse = t.pulse;
                    swing = (t.pulse > prev_pulse) ? t.pulse - prev_pulse
                                                   : prev_pulse - t.pulse;
                    if (swing > SWING_LIMIT) begin
                        if (swing_armed) begin
                            sel_screen = next_enabled_screen(sel_screen);
                            prev_pulse = t.pulse;
                        end else begin
                            swing_armed = 1'b1;
                            keep_flag   = 1'b1;
                        end
                    end
                end
                MODE_RANGE: begin
                    for (int i = 0; i < NSCR; i++) begin
                        lo = cfg_lo[BOUND_W*i +: BOUND_W];
                        hi = cfg_hi[BOUND_W*i +: BOUND_W];
                        if (!hit && screen_enabled(i) && lo <= BOUND_W'(t.pulse)
                            && hi > BOUND_W'(t.pulse)) begin
                            sel_screen = SCR_W'(i);
                            hit        = 1'b1;
                        end
                    end
                end
                default: begin
                    if (t.pulse > cfg_trim) begin
                        if (swing_armed) begin
                            elapsed = t.ms - advance_stamp;
                            if (elapsed > ADVANCE_PERIOD) begin
                                sel_screen    = next_enabled_screen(sel_screen);
                                advance_stamp = t.ms;
                            end
                        end else begin
                            swing_armed = 1'b1;
                            keep_flag   = 1'b1;
                        end
                    end else begin
                        advance_stamp = '0;
                    end
                end
            endcase
            if (!keep_flag)
                swing_armed = 1'b0;
        end
        return sel_screen;
    endfunction

    // Input driver: one tick per beat, random gap after each accepted beat while tx_idle_on is set
    int    tx_gap  = 0;
    logic  tx_busy;
    tick_t tx_tick = '0;

    always @(posedge clk)
    begin
        if (!rst_n) begin
            s_axis_tvalid <= 1'b0;
            tx_gap = 0;
        end else begin
            tx_busy = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready) begin
                screen_q.push_back(select_screen(tx_tick));
                tx_busy = 1'b0;
                tx_gap  = tx_idle_on ? int'($urandom_range(0, 15)) : 0;
            end
            if (!tx_busy) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                end else if (tick_q.size() > 0) begin
                    tx_tick = tick_q.pop_front();
                    tx_busy = 1'b1;
                end
            end
            s_axis_tvalid <= tx_busy;
            s_axis_tdata  <= tx_tick;
        end
    end

    // Result monitor: random stalls, one long hold-off to back up the input
    int               rx_wait = 0;
    logic [SCR_W-1:0] rx_want;

    always @(posedge clk)
    begin
        if (!rst_n) begin
            m_axis_tready <= 1'b0;
            rx_wait = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                if (screen_q.size() == 0) begin
                    report_mismatch($sformatf("result %0d: beat 0x%02h with none expected",
                                              results_seen, m_axis_tdata));
                end else begin
                    rx_want = screen_q.pop_front();
                    if (m_axis_tdata !== {{(OUT_DATA_W-SCR_W){1'b0}}, rx_want})
                        report_mismatch($sformatf("result %0d: shown_screen got 0x%02h want %0d",
                                                  results_seen, m_axis_tdata, rx_want));
                end
                rx_wait = rx_idle_on ? int'($urandom_range(0, 15)) : 0;
                if (results_seen == HOLD_AT)
                    rx_wait = HOLD_LEN;
            end
            if (rx_wait > 0) begin
                rx_wait--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles with no beat on either side
    int stall_cycles = 0;

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_ENABLE_MASK:   cfg_mask   = val[MASK_W-1:0];
            REG_ARM_SCREEN:    cfg_arm    = val[EVT_W-1:0];
            REG_DISARM_SCREEN: cfg_disarm = val[EVT_W-1:0];
            REG_FS_SCREEN:     cfg_fs     = val[EVT_W-1:0];
            REG_SWITCH_MODE:   cfg_mode   = val[MODE_W-1:0];
            REG_CHANNEL_TRIM:  cfg_trim   = val[PULSE_W-1:0];
            REG_RANGE_LOW:     cfg_lo     = val;
            default:           cfg_hi     = val;
        endcase
    endtask

    task automatic load_settings(input logic [MASK_W-1:0] mask, input logic [EVT_W-1:0] arm,
                                 input logic [EVT_W-1:0] disarm, input logic [EVT_W-1:0] fs,
                                 input logic [MODE_W-1:0] mode, input logic [PULSE_W-1:0] trim,
                                 input logic [TABLE_W-1:0] lo, input logic [TABLE_W-1:0] hi);
        write_reg(REG_ENABLE_MASK, CFG_DATA_W'(mask));
        write_reg(REG_ARM_SCREEN, CFG_DATA_W'(arm));
        write_reg(REG_DISARM_SCREEN, CFG_DATA_W'(disarm));
        write_reg(REG_FS_SCREEN, CFG_DATA_W'(fs));
        write_reg(REG_SWITCH_MODE, CFG_DATA_W'(mode));
        write_reg(REG_CHANNEL_TRIM, CFG_DATA_W'(trim));
        write_reg(REG_RANGE_LOW, lo);
        write_reg(REG_RANGE_HIGH, hi);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_random_settings();
        logic [TABLE_W-1:0] lo;
        logic [TABLE_W-1:0] hi;
        logic [BOUND_W-1:0] a;
        logic [BOUND_W-1:0] b;
        logic [MASK_W-1:0]  m;
        logic [PULSE_W-1:0] tr;
        for (int i = 0; i < NSCR; i++) begin
            a = BOUND_W'($urandom_range(0, 4095));
            b = a + BOUND_W'($urandom_range(0, 1500));
            if ($urandom_range(0, 7) == 0) begin
                a = BOUND_W'($urandom);
                b = BOUND_W'($urandom);
            end
            lo[BOUND_W*i +: BOUND_W] = a;
            hi[BOUND_W*i +: BOUND_W] = b;
        end
        case ($urandom_range(0, 5))
            0:       m = '0;
            1:       m = '1;
            default: m = MASK_W'($urandom_range(1, 15));
        endcase
        case ($urandom_range(0, 4))
            0:       tr = '0;
            1:       tr = '1;
            default: tr = PULSE_W'($urandom_range(1000, 2500));
        endcase
        load_settings(m, EVT_W'($urandom_range(0, 4)), EVT_W'($urandom_range(0, 4)),
                      EVT_W'($urandom_range(0, 4)), MODE_W'($urandom_range(0, 3)), tr, lo, hi);
    endtask

    task automatic queue_tick(input bit a, input bit fr, input bit fb, input bit cv,
                              input int pw, input logic [TIME_W-1:0] ms);
        tick_t t;
        t.armed      = a;
        t.fs_radio   = fr;
        t.fs_batt    = fb;
        t.chan_valid = cv;
        t.pulse      = PULSE_W'(pw);
        t.ms         = ms;
        tick_q.push_back(t);
        ticks_queued++;
    endtask

    // Plausible flight: slow flag changes, time mostly moving forward with rare random jumps, pulse swings and holds
    function automatic tick_t random_tick();
        tick_t t;
        int    p;
        if ($urandom_range(0, 99) < 8)
            gen_armed = !gen_armed;
        if ($urandom_range(0, 99) < 6)
            gen_fs_radio = !gen_fs_radio;
        if ($urandom_range(0, 99) < 4)
            gen_fs_batt = !gen_fs_batt;
        if ($urandom_range(0, 15) == 0)
            gen_ms = $urandom;
        else
            gen_ms = gen_ms + $urandom_range(0, 700);
        p = gen_pulse;
        case ($urandom_range(0, 7))
            0, 1:    p = int'($urandom_range(0, 4095));
            2, 3:    p = gen_pulse;
            4, 5:    p = (p > 2047) ? p - int'($urandom_range(201, 1500))
                                    : p + int'($urandom_range(201, 1500));
            6:       p = p + int'($urandom_range(0, 400)) - 200;
            default: p = ($urandom_range(0, 1) != 0) ? 4095 : 0;
        endcase
        if (p < 0)
            p = 0;
        if (p > 4095)
            p = 4095;
        gen_pulse    = p;
        t.armed      = gen_armed;
        t.fs_radio   = gen_fs_radio;
        t.fs_batt    = gen_fs_batt;
        t.chan_valid = ($urandom_range(0, 9) != 0);
        t.pulse      = PULSE_W'(p);
        t.ms         = gen_ms;
        return t;
    endfunction

    // Wait for every result, then let the block go quiet
    task automatic settle();
        while (results_seen != ticks_queued)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    // Stimulus sequence
    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: field extremes, lone enabled screen
        queue_tick(0, 0, 0, 0, 0, 32'h0000_0000);
        queue_tick(1, 1, 1, 1, 4095, 32'hFFFF_FFFF);
        queue_tick(0, 0, 0, 1, 0, 32'h0000_0000);
        queue_tick(0, 0, 0, 1, 0, 32'h0000_0000);
        settle();

        // event jumps, failsafe save and restore, toggle debounce
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        load_settings(4'b1111, 3'd2, 3'd3, 3'd4, MODE_TOGGLE, 12'd1500, '0, '0);
        queue_tick(1, 0, 0, 0, 0, 32'd10);
        queue_tick(1, 1, 0, 0, 0, 32'd20);
        queue_tick(1, 0, 0, 0, 0, 32'd30);
        queue_tick(1, 0, 1, 0, 0, 32'd40);
        queue_tick(1, 1, 1, 0, 0, 32'd50);
        queue_tick(0, 0, 0, 0, 0, 32'd60);
        queue_tick(0, 0, 0, 1, 1000, 32'd70);
        queue_tick(0, 0, 0, 1, 1300, 32'd80);
        queue_tick(0, 0, 0, 1, 1100, 32'd90);
        queue_tick(0, 0, 0, 1, 1300, 32'd100);
        queue_tick(0, 0, 0, 1, 1250, 32'd110);
        settle();

        // range select: disabled match skipped, overlap picks lowest, bounds
        load_settings(4'b1110, 3'd1, 3'd0, 3'd0, MODE_RANGE, 12'd1500,
                      {16'd0, 16'd1500, 16'd1000, 16'd0},
                      {16'hFFFF, 16'd4096, 16'd2000, 16'd1000});
        queue_tick(1, 0, 0, 1, 500, 32'd200);
        queue_tick(1, 0, 0, 1, 1000, 32'd210);
        queue_tick(1, 0, 0, 1, 1999, 32'd220);
        queue_tick(1, 0, 0, 1, 2000, 32'd230);
        queue_tick(1, 0, 0, 0, 1000, 32'd240);
        settle();

        // auto advance with trim at zero, time wrap, exact period
        tx_idle_on = 1'b0;
        load_settings(4'b1111, 3'd0, 3'd0, 3'd0, MODE_AUTO, 12'd0, '1, '1);
        queue_tick(1, 0, 0, 1, 4095, 32'hFFFF_FF00);
        queue_tick(1, 0, 0, 1, 4095, 32'hFFFF_FF00);
        queue_tick(1, 0, 0, 1, 4095, 32'h0000_02E9);
        queue_tick(1, 0, 0, 1, 4095, 32'h0000_06D1);
        queue_tick(1, 0, 0, 1, 0, 32'h0000_0800);
        settle();

        // no screen enabled: events cause no jump, channel unused
        load_settings(4'b0000, 3'd1, 3'd2, 3'd3, MODE_OFF, 12'd4095, '0, '0);
        queue_tick(0, 1, 0, 1, 4095, 32'd3000);
        queue_tick(1, 0, 0, 1, 0, 32'd3100);
        queue_tick(0, 0, 0, 1, 0, 32'd3200);
        settle();

        // failsafe exit when the saved screen has been disabled meanwhile
        load_settings(4'b1111, 3'd2, 3'd0, 3'd4, MODE_OFF, 12'd1500, '0, '0);
        queue_tick(1, 1, 0, 0, 0, 32'd4000);
        settle();
        load_settings(4'b1000, 3'd2, 3'd0, 3'd4, MODE_OFF, 12'd1500, '0, '0);
        queue_tick(1, 0, 0, 0, 0, 32'd4100);
        settle();

        // random phases
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            tx_idle_on = ($urandom_range(0, 2) != 0);
            rx_idle_on = ($urandom_range(0, 2) != 0);
            load_random_settings();
            for (int n = 0; n < PHASE_TICKS; n++) begin
                tick_q.push_back(random_tick());
                ticks_queued++;
            end
            settle();
        end

        repeat (SETTLE_CYC) @(posedge clk);
        if (screen_q.size() != 0)
            report_mismatch($sformatf("%0d expected screens never came out", screen_q.size()));
        if (err_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/oss_pkg.sv
rtl/oss_ctrl.sv
rtl/oss_datapath.sv
rtl/osd_screen_selector.sv
bench/tb_top.sv
